// File: design/ivs_pkg.sv
package ivs_pkg;

   localparam int DEPTH = 32;
   localparam int SLOT_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int RW = ((CNT_W > 7) ? CNT_W : 7) + 2;
   localparam int DEPTH_W = 6;

   typedef enum logic [3:0] {
      OP_PUSH_NIL  = 4'd0,
      OP_PUSH_INT  = 4'd1,
      OP_PUSH_UNS  = 4'd2,
      OP_READ      = 4'd3,
      OP_SET_TOP   = 4'd4,
      OP_PUSH_COPY = 4'd5,
      OP_REMOVE    = 4'd6,
      OP_INSERT    = 4'd7,
      OP_REPLACE   = 4'd8,
      OP_COPY      = 4'd9
   } op_type;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_BADPOS   = 2'd2;
   localparam logic [1:0] ST_NOCHANGE = 2'd3;

   localparam logic [2:0] KIND_EMPTY   = 3'd0;
   localparam logic [2:0] KIND_NIL     = 3'd1;
   localparam logic [2:0] KIND_NUMBER  = 3'd3;
   localparam logic [2:0] KIND_INTEGER = 3'd4;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_WRITE,
      CMD_SET_TOP,
      CMD_REMOVE,
      CMD_INSERT
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type     cmd;
      logic [CNT_W-1:0] a_idx;
      logic             clr_en;
      logic [CNT_W-1:0] top;
      logic [CNT_W-1:0] ntop;
      logic [2:0]       wkind;
      logic [63:0]      wvalue;
   } cell_ctl_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  kind;
      logic [63:0] data;
   } result_type;

endpackage

// File: design/ivs_cell.sv
module ivs_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ivs_pkg::CNT_W-1:0]  my_idx,
   input  ivs_pkg::cell_ctl_type      ctl,
   input  logic [2:0]                 up_kind,
   input  logic [63:0]                up_value,
   input  logic [2:0]                 dn_kind,
   input  logic [63:0]                dn_value,
   output logic [2:0]                 kind,
   output logic [63:0]                value
);
   import ivs_pkg::*;

   logic [2:0]       kind_ff, kind_in;
   logic [63:0]      value_ff, value_in;
   logic [CNT_W-1:0] idx_p1;

   assign idx_p1 = my_idx + 1'b1;

   always_comb begin
      kind_in = kind_ff;
      value_in = value_ff;
      unique case (ctl.cmd)
         CMD_WRITE: begin
            if (my_idx == ctl.a_idx) begin
               kind_in = ctl.wkind;
               value_in = ctl.wvalue;
            end else if (ctl.clr_en && idx_p1 == ctl.top) begin
               kind_in = KIND_EMPTY;
               value_in = '0;
            end
         end
         CMD_SET_TOP: begin
            if (my_idx >= ctl.top && my_idx < ctl.ntop) begin
               kind_in = KIND_NIL;
               value_in = '0;
            end else if (my_idx >= ctl.ntop && my_idx < ctl.top) begin
               kind_in = KIND_EMPTY;
               value_in = '0;
            end
         end
         CMD_REMOVE: begin
            if (my_idx >= ctl.a_idx && idx_p1 < ctl.top) begin
               kind_in = up_kind;
               value_in = up_value;
            end else if (idx_p1 == ctl.top) begin
               kind_in = KIND_EMPTY;
               value_in = '0;
            end
         end
         CMD_INSERT: begin
            if (my_idx == ctl.a_idx) begin
               kind_in = ctl.wkind;
               value_in = ctl.wvalue;
            end else if (my_idx > ctl.a_idx && my_idx < ctl.top) begin
               kind_in = dn_kind;
               value_in = dn_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_EMPTY;
         value_ff <= '0;
      end else begin
         kind_ff <= kind_in;
         value_ff <= value_in;
      end
   end

   assign kind = kind_ff;
   assign value = value_ff;

endmodule

// File: design/ivs_ctrl.sv
module ivs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        exec,
   input  logic [3:0]                  operation,
   input  logic signed [6:0]           position,
   input  logic signed [6:0]           second_position,
   input  logic [63:0]                 push_data,
   input  logic [2:0]                  rd_kind,
   input  logic [63:0]                 rd_value,
   output logic [ivs_pkg::SLOT_W-1:0]  rd_idx,
   output ivs_pkg::cell_ctl_type       ctl,
   output ivs_pkg::result_type         res,
   output logic [ivs_pkg::CNT_W-1:0]   top_next
);
   import ivs_pkg::*;

   logic [CNT_W-1:0]  top_ff, top_in, topm1, nt;
   logic signed [RW-1:0] pe, qe, top_s, sp, sq, cl;
   logic p_occ, q_occ, full, rd_ok;
   op_type op;
   cell_ctl_type c;

   assign op = op_type'(operation);
   assign topm1 = top_ff - 1'b1;
   assign pe = {{(RW-7){position[6]}}, position};
   assign qe = {{(RW-7){second_position[6]}}, second_position};
   assign top_s = signed'({{(RW-CNT_W){1'b0}}, top_ff});
   assign sp = (pe > 0) ? pe - RW'(1) : pe + top_s;
   assign sq = (qe > 0) ? qe - RW'(1) : qe + top_s;
   assign p_occ = (pe != 0) && (sp >= 0) && (sp < top_s);
   assign q_occ = (qe != 0) && (sq >= 0) && (sq < top_s);
   assign rd_ok = (pe != 0) && (sp >= 0) && (sp < RW'(DEPTH));
   assign full = (top_ff == CNT_W'(DEPTH));
   assign cl = (sp < 0) ? '0 : ((sp > RW'(DEPTH - 1)) ? RW'(DEPTH - 1) : sp);
   assign nt = (pe == 0) ? '0 : (cl[CNT_W-1:0] + 1'b1);
   assign rd_idx = (op == OP_INSERT || op == OP_REPLACE) ? topm1[SLOT_W-1:0]
                                                         : sp[SLOT_W-1:0];

   always_comb begin
      c.cmd = CMD_NONE;
      c.a_idx = top_ff;
      c.clr_en = 1'b0;
      c.top = top_ff;
      c.ntop = nt;
      c.wkind = rd_kind;
      c.wvalue = rd_value;
      res.status = ST_DONE;
      res.kind = KIND_EMPTY;
      res.data = '0;
      top_in = top_ff;
      case (op)
         OP_PUSH_NIL, OP_PUSH_INT, OP_PUSH_UNS: begin
            if (full) begin
               res.status = ST_FULL;
            end else begin
               c.cmd = CMD_WRITE;
               top_in = top_ff + 1'b1;
               if (op == OP_PUSH_NIL) begin
                  c.wkind = KIND_NIL;
                  c.wvalue = '0;
               end else if (op == OP_PUSH_INT) begin
                  c.wkind = KIND_INTEGER;
                  c.wvalue = push_data;
               end else begin
                  c.wkind = KIND_NUMBER;
                  c.wvalue = {32'd0, push_data[31:0]};
               end
            end
         end
         OP_READ: begin
            if (rd_ok) begin
               res.kind = rd_kind;
               res.data = rd_value;
            end else begin
               res.status = ST_BADPOS;
            end
         end
         OP_SET_TOP: begin
            if (nt == top_ff) begin
               res.status = ST_NOCHANGE;
            end else begin
               c.cmd = CMD_SET_TOP;
               top_in = nt;
            end
         end
         OP_PUSH_COPY: begin
            if (!p_occ) begin
               res.status = ST_BADPOS;
            end else if (full) begin
               res.status = ST_FULL;
            end else begin
               c.cmd = CMD_WRITE;
               top_in = top_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!p_occ) begin
               res.status = ST_BADPOS;
            end else begin
               c.cmd = CMD_REMOVE;
               c.a_idx = sp[CNT_W-1:0];
               top_in = topm1;
            end
         end
         OP_INSERT, OP_REPLACE: begin
            if (!p_occ) begin
               res.status = ST_BADPOS;
            end else if (sp[CNT_W-1:0] == topm1) begin
               res.status = ST_NOCHANGE;
            end else begin
               c.a_idx = sp[CNT_W-1:0];
               if (op == OP_INSERT) begin
                  c.cmd = CMD_INSERT;
               end else begin
                  c.cmd = CMD_WRITE;
                  c.clr_en = 1'b1;
                  top_in = topm1;
               end
            end
         end
         OP_COPY: begin
            if (position == second_position) begin
               res.status = ST_NOCHANGE;
            end else if (!p_occ || !q_occ) begin
               res.status = ST_BADPOS;
            end else begin
               c.cmd = CMD_WRITE;
               c.a_idx = sq[CNT_W-1:0];
            end
         end
         default: begin
            res.status = ST_NOCHANGE;
         end
      endcase
      if (!exec) begin
         c.cmd = CMD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else if (exec) begin
         top_ff <= top_in;
      end
   end

   assign ctl = c;
   assign top_next = top_in;

endmodule

// File: design/indexed_value_stack.sv
// Bounded stack of typed 64-bit slots addressed by position (positive from the
// bottom at 1, negative from the top). Each slot is a cell of its own, so
// shifts, nil fills and clears happen across all cells in the same cycle. A
// request is first captured, then positions are resolved and the cells updated
// while the response register is loaded, held off while a response stalls. A
// new request is taken while the previous response still waits, not while busy.
module indexed_value_stack (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_operation,
   input  logic signed [6:0]  req_position,
   input  logic signed [6:0]  req_second_position,
   input  logic signed [63:0] req_push_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [2:0]         rsp_slot_kind,
   output logic signed [63:0] rsp_slot_data,
   output logic [5:0]         rsp_depth_count
);
   import ivs_pkg::*;

   logic              busy_ff, rsp_valid_ff;
   logic [3:0]        op_ff;
   logic signed [6:0] p_ff, q_ff;
   logic [63:0]       data_ff;
   result_type        res, res_ff;
   logic [CNT_W-1:0]  top_next;
   logic [DEPTH_W-1:0] depth_ff;
   logic              exec, accept;
   logic [SLOT_W-1:0] rd_idx;
   cell_ctl_type      ctl;
   logic [2:0]        kinds [DEPTH];
   logic [63:0]       values [DEPTH];

   assign accept = req_valid && !busy_ff;
   assign exec = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (exec) begin
            busy_ff <= 1'b0;
         end
         if (exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_operation;
         p_ff <= req_position;
         q_ff <= req_second_position;
         data_ff <= req_push_data;
      end
      if (exec) begin
         res_ff <= res;
         depth_ff <= DEPTH_W'(top_next);
      end
   end

   ivs_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .exec            (exec),
      .operation       (op_ff),
      .position        (p_ff),
      .second_position (q_ff),
      .push_data       (data_ff),
      .rd_kind         (kinds[rd_idx]),
      .rd_value        (values[rd_idx]),
      .rd_idx          (rd_idx),
      .ctl             (ctl),
      .res             (res),
      .top_next        (top_next)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [2:0]  up_k, dn_k;
      logic [63:0] up_v, dn_v;
      if (i + 1 < DEPTH) begin : g_up
         assign up_k = kinds[i+1];
         assign up_v = values[i+1];
      end else begin : g_top
         assign up_k = KIND_EMPTY;
         assign up_v = '0;
      end
      if (i > 0) begin : g_dn
         assign dn_k = kinds[i-1];
         assign dn_v = values[i-1];
      end else begin : g_bot
         assign dn_k = KIND_EMPTY;
         assign dn_v = '0;
      end
      ivs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .my_idx   (CNT_W'(i)),
         .ctl      (ctl),
         .up_kind  (up_k),
         .up_value (up_v),
         .dn_kind  (dn_k),
         .dn_value (dn_v),
         .kind     (kinds[i]),
         .value    (values[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = res_ff.status;
   assign rsp_slot_kind = res_ff.kind;
   assign rsp_slot_data = res_ff.data;
   assign rsp_depth_count = depth_ff;

endmodule
